// ===== hdl/bkkd_pkg.sv =====
// shared types, constants and a helper function for the keystream decryptor
package bkkd_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int CFG_ADDR_W = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  localparam word_t MIX_GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam word_t MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam word_t RESEED_SALT = 64'h0000_0005_DEEC_E66D;

  // register index, taken from the top address bit
  localparam logic REG_KEY = 1'b0;

  typedef enum logic [1:0] {
    MP_LL,
    MP_HL,
    MP_LH
  } mul_phase_t;

  typedef struct packed {
    logic       en;
    mul_phase_t phase;
  } mul_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_SHIFT_B,
    ST_MUL_B,
    ST_FINISH
  } seq_state_t;

  // golden add and first xor-shift of the finalizer
  function automatic word_t pre_mix(word_t x);
    word_t v;
    v = x + MIX_GOLDEN;
    return v ^ (v >> 30);
  endfunction

endpackage

// ===== hdl/bkkd_in_if.sv =====
// input channel: cipher words with stream and block marks
interface bkkd_in_if;
  import bkkd_pkg::*;

  logic  valid;
  logic  ready;
  word_t cipher_word;
  logic  stream_start;
  logic  block_start;

  modport source(output valid, cipher_word, stream_start, block_start, input ready);
  modport sink(input valid, cipher_word, stream_start, block_start, output ready);
endinterface

// ===== hdl/bkkd_out_if.sv =====
// result channel: decrypted plain words
interface bkkd_out_if;
  import bkkd_pkg::*;

  logic  valid;
  logic  ready;
  word_t plain_word;

  modport source(output valid, plain_word, input ready);
  modport sink(input valid, plain_word, output ready);
endinterface

// ===== hdl/bkkd_mul.sv =====
// shared 32x32 multiplier with accumulator, builds a 64-bit truncated product in three steps
module bkkd_mul (
  input  logic               clk,
  input  bkkd_pkg::mul_cmd_t cmd,
  input  bkkd_pkg::word_t    op_a,
  input  bkkd_pkg::word_t    op_b,
  output bkkd_pkg::word_t    prod
);
  import bkkd_pkg::*;

  half_t mx;
  half_t my;
  word_t pp;
  word_t acc_r;
  word_t acc_nxt;

  always_comb begin
    case (cmd.phase)
      MP_LL: begin
        mx = op_a[HALF_W-1:0];
        my = op_b[HALF_W-1:0];
      end
      MP_HL: begin
        mx = op_a[WORD_W-1:HALF_W];
        my = op_b[HALF_W-1:0];
      end
      MP_LH: begin
        mx = op_a[HALF_W-1:0];
        my = op_b[WORD_W-1:HALF_W];
      end
      default: begin
        mx = op_a[HALF_W-1:0];
        my = op_b[HALF_W-1:0];
      end
    endcase
  end

  assign pp = WORD_W'(mx) * WORD_W'(my);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.en) begin
      case (cmd.phase)
        MP_LL:   acc_nxt = pp;
        // cross terms only reach the upper half
        MP_HL,
        MP_LH:   acc_nxt = acc_r + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
        default: acc_nxt = pp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;

endmodule

// ===== hdl/bkkd_seq.sv =====
// sequencer and chain datapath: drives the shared multiplier through each finalizer pass
module bkkd_seq (
  input  logic               clk,
  input  logic               rst_n,
  bkkd_in_if.sink            in_ch,
  bkkd_out_if.source         out_ch,
  input  bkkd_pkg::word_t    key,
  output bkkd_pkg::mul_cmd_t mul_cmd,
  output bkkd_pkg::word_t    mul_a,
  output bkkd_pkg::word_t    mul_b,
  input  bkkd_pkg::word_t    mul_prod
);
  import bkkd_pkg::*;

  seq_state_t state_r, state_nxt;
  mul_phase_t phase_r, phase_nxt;
  logic       reseed_r, reseed_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      op_r, op_nxt;
  word_t      chain_r, chain_nxt;
  word_t      word_r, word_nxt;
  word_t      out_word_r, out_word_nxt;
  word_t      shifted_b;
  word_t      mix_out;
  logic       in_acc;
  logic       mul_last;

  assign shifted_b = mul_prod ^ (mul_prod >> 27);
  assign mix_out   = mul_prod ^ (mul_prod >> 31);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.plain_word = out_word_r;

  assign mul_cmd.en    = (state_r == ST_MUL_A) || (state_r == ST_MUL_B);
  assign mul_cmd.phase = phase_r;
  assign mul_a         = op_r;
  assign mul_b         = (state_r == ST_MUL_B) ? MIX_MUL_B : MIX_MUL_A;
  assign mul_last      = (phase_r == MP_LH);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    reseed_nxt    = reseed_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    chain_nxt     = chain_r;
    word_nxt      = word_r;
    out_word_nxt  = out_word_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          word_nxt  = in_ch.cipher_word;
          phase_nxt = MP_LL;
          state_nxt = ST_MUL_A;
          if (in_ch.stream_start) begin
            op_nxt     = pre_mix(key);
            reseed_nxt = 1'b0;
          end else if (in_ch.block_start) begin
            op_nxt     = pre_mix(chain_r ^ RESEED_SALT);
            reseed_nxt = 1'b1;
          end else begin
            op_nxt     = pre_mix(chain_r);
            reseed_nxt = 1'b0;
          end
        end
      end
      ST_MUL_A,
      ST_MUL_B: begin
        case (phase_r)
          MP_LL:   phase_nxt = MP_HL;
          MP_HL:   phase_nxt = MP_LH;
          MP_LH:   phase_nxt = MP_LL;
          default: phase_nxt = MP_LL;
        endcase
        if (mul_last) begin
          state_nxt = (state_r == ST_MUL_A) ? ST_SHIFT_B : ST_FINISH;
        end
      end
      ST_SHIFT_B: begin
        op_nxt    = shifted_b;
        phase_nxt = MP_LL;
        state_nxt = ST_MUL_B;
      end
      ST_FINISH: begin
        if (reseed_r) begin
          // reseed pass done, now the regular advance
          op_nxt     = pre_mix(mix_out);
          reseed_nxt = 1'b0;
          phase_nxt  = MP_LL;
          state_nxt  = ST_MUL_A;
        end else if (!out_valid_r || out_ch.ready) begin
          chain_nxt     = mix_out;
          out_word_nxt  = word_r ^ mix_out;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= MP_LL;
      reseed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      reseed_r    <= reseed_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    word_r     <= word_nxt;
    out_word_r <= out_word_nxt;
  end

  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL_A) && (phase_r == MP_LL))
    else $error("accepted request did not start the first multiply");

  a_mul_a_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_A) && (phase_r == MP_LH) |=> (state_r == ST_SHIFT_B))
    else $error("first multiply did not hand over to the shift step");

  a_reseed_loops_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && reseed_r |=> (state_r == ST_MUL_A) && !reseed_r)
    else $error("reseed pass did not return for the regular advance");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && !reseed_r && (!out_valid_r || out_ch.ready)
      |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished word was not presented");

endmodule

// ===== hdl/bkkd_cfg.sv =====
// apb-style register file holding the stream key
module bkkd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bkkd_pkg::CFG_ADDR_W-1:0] paddr,
  input  bkkd_pkg::word_t                 pwdata,
  output bkkd_pkg::word_t                 prdata,
  output logic                            pready,
  output bkkd_pkg::word_t                 key
);
  import bkkd_pkg::*;

  word_t key_r, key_nxt;
  logic  sel_key;

  assign sel_key = (paddr[CFG_ADDR_W-1] == REG_KEY);
  assign pready  = 1'b1;
  assign prdata  = sel_key ? key_r : '0;
  assign key     = key_r;

  always_comb begin
    key_nxt = key_r;
    if (psel && penable && pwrite && sel_key) begin
      key_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

endmodule

// ===== hdl/block_keyed_keystream_decrypt_top.sv =====
// top level of the keyed keystream decryptor
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid/ready      cipher_word[63:0], stream_start, block_start
//   out_ch    source     valid/ready      plain_word[63:0]
//   apb       slave      psel/penable     paddr[3:0], pwdata/prdata[63:0], key at 0x0
//
// the input is not ready again until the finished word is loaded into the output register;
// a block-start reseed runs a second finalizer pass first. each pass is two 64-bit multiplies
// of 3 steps on the shared 32x32 unit plus the shift step between them and the finish step
// a finished word waits in the output register while the next request is taken;
// the sequencer stalls in its last step only if that register is still full
// rst_n is synchronous: chain and key clear to zero, no request pending
module block_keyed_keystream_decrypt_top (
  input  logic                            clk,
  input  logic                            rst_n,
  bkkd_in_if.sink                         in_ch,
  bkkd_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bkkd_pkg::CFG_ADDR_W-1:0] paddr,
  input  bkkd_pkg::word_t                 pwdata,
  output bkkd_pkg::word_t                 prdata,
  output logic                            pready
);
  import bkkd_pkg::*;

  word_t    key;
  mul_cmd_t mul_cmd;
  word_t    mul_a;
  word_t    mul_b;
  word_t    mul_prod;

  bkkd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  bkkd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .key      (key),
    .mul_cmd  (mul_cmd),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_prod (mul_prod)
  );

  bkkd_mul u_mul (
    .clk  (clk),
    .cmd  (mul_cmd),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

endmodule

// ===== tb/block_keyed_keystream_decrypt_top_test.sv =====
// testbench for the keyed keystream decryptor: directed and random word streams, checked per word
module block_keyed_keystream_decrypt_top_test;
  import bkkd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] KEY_ADDR   = {REG_KEY, {(CFG_ADDR_W-1){1'b0}}};
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = {~REG_KEY, {(CFG_ADDR_W-1){1'b0}}};
  localparam word_t ALL_ONES = {WORD_W{1'b1}};

  class keystream_model;
    word_t       key_reg;
    word_t       chain;
    word_t       pending_plain[$];
    int unsigned errors;

    function new();
      key_reg = '0;
      chain   = '0;
      errors  = 0;
    endfunction

    static function word_t splitmix_step(word_t x);
      word_t v;
      v = x + MIX_GOLDEN;
      v = (v ^ (v >> 30)) * MIX_MUL_A;
      v = (v ^ (v >> 27)) * MIX_MUL_B;
      return v ^ (v >> 31);
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, word_t data);
      if (addr[CFG_ADDR_W-1] == REG_KEY) key_reg = data;
    endfunction

    function void note_request(word_t cipher, logic stream_start, logic block_start);
      if (stream_start)
        chain = key_reg;
      else if (block_start)
        chain = splitmix_step(chain ^ RESEED_SALT);
      chain = splitmix_step(chain);
      pending_plain.push_back(cipher ^ chain);
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("ERROR %s", msg);
      errors++;
    endtask

    task check_plain(word_t plain);
      word_t want;
      if (pending_plain.size() == 0) begin
        report_mismatch($sformatf("plain_word %h arrived with nothing outstanding", plain));
      end else begin
        want = pending_plain.pop_front();
        if (plain !== want)
          report_mismatch($sformatf("plain_word got %h expected %h", plain, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  word_t pwdata;
  word_t prdata;
  logic  pready;
  bit    no_idle;

  keystream_model model = new();

  bkkd_in_if  in_bus();
  bkkd_out_if out_bus();

  block_keyed_keystream_decrypt_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus.sink),
    .out_ch  (out_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t pick_cipher();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, word_t data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high after acceptance so a zero gap gives back-to-back requests
  task automatic send_word(word_t cipher, logic stream_start, logic block_start);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.cipher_word  <= cipher;
    in_bus.stream_start <= stream_start;
    in_bus.block_start  <= block_start;
    do @(posedge clk); while (!in_bus.ready);
    model.note_request(cipher, stream_start, block_start);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (model.pending_plain.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side: random back-pressure, short stalls mostly, long ones now and then
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) model.check_plain(out_bus.plain_word);
      r = $urandom_range(0, 99);
      if (no_idle) begin
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (r < 65) begin
        out_bus.ready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_bus.ready <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("block_keyed_keystream_decrypt_top: mismatch");
    $finish;
  end

  initial begin
    int unsigned n;
    bit          started;
    int unsigned r;
    in_bus.valid        = 1'b0;
    in_bus.cipher_word  = '0;
    in_bus.stream_start = 1'b0;
    in_bus.block_start  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    no_idle = 1'b0;
    rst_n   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // words before any stream start run off the reset chain
    send_word('0, 1'b0, 1'b0);
    send_word(ALL_ONES, 1'b0, 1'b1);
    send_word(pick_cipher(), 1'b0, 1'b0);
    wait_idle();

    write_cfg(KEY_ADDR, ALL_ONES);
    send_word('0, 1'b1, 1'b0);
    send_word(ALL_ONES, 1'b0, 1'b0);
    send_word(pick_cipher(), 1'b0, 1'b1);
    // both marks: stream start wins, no reseed
    send_word(pick_cipher(), 1'b1, 1'b1);
    send_word(pick_cipher(), 1'b0, 1'b1);
    wait_idle();

    // new key mid-stream leaves the running chain alone
    write_cfg(KEY_ADDR, {$urandom, $urandom});
    send_word(pick_cipher(), 1'b0, 1'b0);
    send_word(pick_cipher(), 1'b0, 1'b1);
    wait_idle();

    // write to an unused register is dropped
    write_cfg(UNUSED_ADDR, {$urandom, $urandom});
    send_word(pick_cipher(), 1'b1, 1'b0);
    send_word(pick_cipher(), 1'b0, 1'b0);
    wait_idle();

    write_cfg(KEY_ADDR, '0);
    send_word(pick_cipher(), 1'b1, 1'b0);
    send_word(pick_cipher(), 1'b0, 1'b1);
    send_word(pick_cipher(), 1'b0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_cfg(KEY_ADDR, '0);
        1: write_cfg(KEY_ADDR, ALL_ONES);
        3: write_cfg(KEY_ADDR, {1'b1, {(WORD_W-1){1'b0}}});
        default: write_cfg(KEY_ADDR, {$urandom, $urandom});
      endcase
      if (ph == 4) write_cfg(UNUSED_ADDR, {$urandom, $urandom});
      no_idle = (ph == 2);
      started = 1'b0;
      for (n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        if (!started || r < 6) begin
          send_word(pick_cipher(), 1'b1, 1'($urandom_range(0, 1)));
          started = 1'b1;
        end else if (r < 14) begin
          // noise: marks at random
          send_word(pick_cipher(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          send_word(pick_cipher(), 1'b0, ($urandom_range(0, 99) < 20));
        end
        if (!no_idle && $urandom_range(0, 99) < 2) wait_idle();
      end
      wait_idle();
    end
    no_idle = 1'b0;

    repeat (40) @(posedge clk);
    if (model.errors == 0 && model.pending_plain.size() == 0) begin
      $display("block_keyed_keystream_decrypt_top: match");
    end else begin
      $display("block_keyed_keystream_decrypt_top: mismatch");
    end
    $finish;
  end

endmodule
